// ===== rtl/put_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package put_pkg;

  // Fixed-point format and limits
  localparam int FRAC_BITS     = 8;
  localparam int MAX_INTERVALS = 4;
  localparam int ALPHA_ONE     = 1 << FRAC_BITS;
  localparam int ALPHA_W       = FRAC_BITS + 1;

  // Shared divider geometry: signed numerator, unsigned 16-bit divisor
  localparam int NUM_W    = 37;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DIV_STEP = 4;
  localparam int DIV_ITER = MAG_W / DIV_STEP;
  localparam int ALPHA_PAD = NUM_W - 16 - FRAC_BITS;

  // Configuration register indexes
  localparam logic [2:0] CFG_DT    = 3'd0;
  localparam logic [2:0] CFG_CTL   = 3'd1;
  localparam logic [2:0] CFG_SMIN  = 3'd2;
  localparam logic [2:0] CFG_SMAX  = 3'd3;
  localparam logic [2:0] CFG_ACC   = 3'd4;
  localparam logic [2:0] CFG_EMIT  = 3'd5;
  localparam logic [2:0] CFG_INTV  = 3'd6;
  localparam logic [2:0] CFG_CNT   = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_UPD   = 2'd0;
  localparam logic [1:0] KIND_CHILD = 2'd1;
  localparam logic [1:0] KIND_EXP   = 2'd2;

  // Scale modes
  localparam logic [1:0] SMODE_UP   = 2'd1;
  localparam logic [1:0] SMODE_DOWN = 2'd2;

  // Move phases
  localparam logic [2:0] MV_NONE = 3'd0;
  localparam logic [2:0] MV_A    = 3'd1;
  localparam logic [2:0] MV_B    = 3'd2;
  localparam logic [2:0] MV_C    = 3'd3;
  localparam logic [2:0] MV_D    = 3'd4;
  localparam logic [2:0] MV_E    = 3'd5;

  // Division operations
  localparam logic [2:0] OP_SCALE  = 3'd0;
  localparam logic [2:0] OP_PALPHA = 3'd1;
  localparam logic [2:0] OP_CX     = 3'd2;
  localparam logic [2:0] OP_CY     = 3'd3;
  localparam logic [2:0] OP_CZ     = 3'd4;
  localparam logic [2:0] OP_CAGE   = 3'd5;
  localparam logic [2:0] OP_CALPHA = 3'd6;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] scale_in;
    logic [15:0]        age_in;
    logic [15:0]        lifetime;
    logic [15:0]        spawn_timer_in;
    logic               is_parent;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic signed [15:0] out_pos_z;
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic signed [15:0] out_vel_z;
    logic signed [15:0] out_scale;
    logic [15:0]        out_age;
    logic [ALPHA_W-1:0] alpha;
    logic [15:0]        out_spawn_timer;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic       load_in;
    logic [2:0] mv;
    logic       num_load;
    logic [2:0] num_op;
    logic       div_start;
    logic       store;
    logic       tm_step;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
    logic [3:0] child_i;
  } put_cmd_t;

  typedef struct packed {
    logic       expired;
    logic       trail;
    logic       smode_on;
    logic       tm_ge;
    logic [3:0] cnt_n;
    logic       out_free;
    logic       div_done;
  } put_sts_t;

  // p + floor(prod / 2^FRAC_BITS), saturated to 16 bits
  function automatic logic signed [15:0] step_add(input logic signed [15:0] p,
                                                  input logic signed [32:0] prod);
    logic signed [25:0] s;
    s = $signed({{10{p[15]}}, p}) + $signed({prod[32], prod[32:FRAC_BITS]});
    if (s > 26'sd32767)       step_add = 16'sh7fff;
    else if (s < -26'sd32768) step_add = 16'sh8000;
    else                      step_add = s[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/put_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module put_div
  import put_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [15:0]             den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quot
);

  logic [MAG_W-1:0] mag_r;
  logic [15:0]      rem_r;
  logic [15:0]      den_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [3:0]       cnt_r;
  logic signed [NUM_W-1:0] quot_r;

  logic [MAG_W-1:0] mag_nxt;
  logic [15:0]      rem_nxt;
  logic [NUM_W-1:0] abs_num;
  logic [NUM_W-1:0] qpos;

  // Radix-16 restoring step: four quotient bits per cycle
  always_comb begin
    logic [16:0] r;
    logic [MAG_W-1:0] m;
    r = {1'b0, rem_r};
    m = mag_r;
    for (int s = 0; s < DIV_STEP; s++) begin
      r = {r[15:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
      if (r >= {1'b0, den_r}) begin
        r = r - {1'b0, den_r};
        m[0] = 1'b1;
      end
    end
    mag_nxt = m;
    rem_nxt = r[15:0];
  end

  assign abs_num = num[NUM_W-1] ? -num : num;
  assign qpos    = {1'b0, mag_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and quotient; floor correction on the final step
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= abs_num[MAG_W-1:0];
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == 4'(DIV_ITER - 1)) begin
        if (!neg_r)               quot_r <= $signed(qpos);
        else if (rem_nxt != 16'd0) quot_r <= $signed(~qpos);
        else                      quot_r <= $signed(-qpos);
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/put_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module put_dp
  import put_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire put_cmd_t    cmd,
  output put_sts_t         sts,
  input  wire logic        out_stall,
  output logic             out_valid,
  output out_item_t        out_data
);

  // Configuration registers
  logic [15:0] dt_r;
  logic [5:0]  ctl_r;
  logic [15:0] smin_r;
  logic [15:0] smax_r;
  logic [47:0] acc_r;
  logic [47:0] emit_r;
  logic [15:0] intv_r;
  logic [3:0]  cnt_r;

  // Particle working registers
  logic signed [15:0] oldp_r [3];
  logic signed [15:0] p_r    [3];
  logic signed [15:0] v_r    [3];
  logic signed [32:0] prod_r [3];
  logic signed [15:0] cp_r   [3];
  logic signed [15:0] sc_r;
  logic [15:0]        age0_r;
  logic [15:0]        age1_r;
  logic [15:0]        life_r;
  logic [15:0]        tm_r;
  logic               par_r;
  logic [15:0]        ca_r;
  logic [ALPHA_W-1:0] palpha_r;
  logic [ALPHA_W-1:0] calpha_r;
  logic signed [NUM_W-1:0] num_r;
  logic [15:0]        den_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic                    div_done;
  logic signed [NUM_W-1:0] quot;
  logic [1:0]              smode;
  logic                    translate;
  logic                    follow;
  logic                    dirn;
  logic [16:0]             age_sum;
  logic [16:0]             tm_sum;
  logic                    out_free;

  assign smode     = ctl_r[5:4];
  assign translate = ctl_r[0];
  assign follow    = ctl_r[1];
  assign dirn      = ctl_r[2];
  assign age_sum   = {1'b0, in_data.age_in} + {1'b0, dt_r};
  assign tm_sum    = {1'b0, in_data.spawn_timer_in} + {1'b0, dt_r};
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r   <= 16'd4;
      ctl_r  <= 6'd1;
      smin_r <= 16'd0;
      smax_r <= 16'd256;
      acc_r  <= '0;
      emit_r <= '0;
      intv_r <= 16'd256;
      cnt_r  <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DT:   dt_r   <= cfg_data[15:0];
        CFG_CTL:  ctl_r  <= cfg_data[5:0];
        CFG_SMIN: smin_r <= cfg_data[15:0];
        CFG_SMAX: smax_r <= cfg_data[15:0];
        CFG_ACC:  acc_r  <= cfg_data;
        CFG_EMIT: emit_r <= cfg_data;
        CFG_INTV: intv_r <= cfg_data[15:0];
        CFG_CNT:  cnt_r  <= cfg_data[3:0];
        default:  ;
      endcase
    end
  end

  // Motion lanes: one multiplier per axis, operand picked by phase
  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic signed [15:0] mop;
    logic signed [32:0] mul;
    logic signed [15:0] pin;
    logic signed [15:0] vin;
    assign mop = (cmd.mv == MV_B) ? $signed(acc_r[16*j +: 16]) : v_r[j];
    assign mul = mop * $signed({1'b0, dt_r});
    assign pin = (j == 0) ? in_data.pos_x : (j == 1) ? in_data.pos_y : in_data.pos_z;
    assign vin = (j == 0) ? in_data.vel_x : (j == 1) ? in_data.vel_y : in_data.vel_z;

    always_ff @(posedge clk) begin
      if (cmd.load_in) begin
        oldp_r[j] <= pin;
        p_r[j]    <= pin;
        v_r[j]    <= vin;
      end else begin
        case (cmd.mv)
          MV_A, MV_D: prod_r[j] <= mul;
          MV_B: begin
            prod_r[j] <= mul;
            if (translate)
              p_r[j] <= follow ? $signed(emit_r[16*j +: 16]) : step_add(p_r[j], prod_r[j]);
          end
          MV_C: if (translate && dirn) v_r[j] <= step_add(v_r[j], prod_r[j]);
          MV_E: if (translate && dirn) p_r[j] <= step_add(p_r[j], prod_r[j]);
          default: ;
        endcase
      end
    end
  end

  // Numerator and divisor selection
  logic signed [16:0] sdiff;
  logic signed [15:0] sbase;
  logic signed [33:0] snum;
  logic signed [21:0] cnum [3];
  logic [20:0]        anum;
  logic signed [NUM_W-1:0] num_sel;
  logic [15:0]        den_sel;

  always_comb begin
    if (smode == SMODE_UP) begin
      sbase = $signed(smin_r);
      sdiff = $signed({smax_r[15], smax_r}) - $signed({smin_r[15], smin_r});
    end else begin
      sbase = $signed(smax_r);
      sdiff = $signed({smin_r[15], smin_r}) - $signed({smax_r[15], smax_r});
    end
    snum = sdiff * $signed({1'b0, age0_r});
    for (int j = 0; j < 3; j++)
      cnum[j] = ($signed({p_r[j][15], p_r[j]}) - $signed({oldp_r[j][15], oldp_r[j]}))
                * $signed({1'b0, cmd.child_i});
    anum = ({1'b0, age1_r} - {1'b0, age0_r}) * {1'b0, cmd.child_i};
    den_sel = {11'd0, ({1'b0, cnt_r} + 5'd1)};
    case (cmd.num_op)
      OP_SCALE: begin
        num_sel = {{(NUM_W-34){snum[33]}}, snum};
        den_sel = life_r;
      end
      OP_PALPHA: begin
        num_sel = $signed({{ALPHA_PAD{1'b0}}, age1_r, {FRAC_BITS{1'b0}}});
        den_sel = life_r;
      end
      OP_CX:   num_sel = {{(NUM_W-22){cnum[0][21]}}, cnum[0]};
      OP_CY:   num_sel = {{(NUM_W-22){cnum[1][21]}}, cnum[1]};
      OP_CZ:   num_sel = {{(NUM_W-22){cnum[2][21]}}, cnum[2]};
      OP_CAGE: num_sel = $signed({{(NUM_W-21){1'b0}}, anum});
      OP_CALPHA: begin
        num_sel = $signed({{ALPHA_PAD{1'b0}}, ca_r, {FRAC_BITS{1'b0}}});
        den_sel = life_r;
      end
      default: num_sel = '0;
    endcase
  end

  put_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  // Alpha from quotient of age * ALPHA_ONE / life, clamped at zero
  logic [ALPHA_W-1:0] q_alpha;
  assign q_alpha = (quot > $signed(NUM_W'(ALPHA_ONE))) ? '0
                 : ALPHA_W'(ALPHA_ONE) - quot[ALPHA_W-1:0];

  // Per-particle scalars, division results and spawn timer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sc_r   <= in_data.scale_in;
      age0_r <= in_data.age_in;
      life_r <= in_data.lifetime;
      par_r  <= in_data.is_parent;
      age1_r <= age_sum[16] ? 16'hffff : age_sum[15:0];
      if (ctl_r[3] && in_data.is_parent)
        tm_r <= tm_sum[16] ? 16'hffff : tm_sum[15:0];
      else
        tm_r <= in_data.spawn_timer_in;
    end else if (cmd.tm_step) begin
      tm_r <= tm_r - intv_r;
    end
    if (cmd.num_load) begin
      num_r <= num_sel;
      den_r <= den_sel;
    end
    if (cmd.store) begin
      case (cmd.num_op)
        OP_SCALE:  sc_r     <= sbase + quot[15:0];
        OP_PALPHA: palpha_r <= q_alpha;
        OP_CX:     cp_r[0]  <= oldp_r[0] + quot[15:0];
        OP_CY:     cp_r[1]  <= oldp_r[1] + quot[15:0];
        OP_CZ:     cp_r[2]  <= oldp_r[2] + quot[15:0];
        OP_CAGE:   ca_r     <= age0_r + quot[15:0];
        OP_CALPHA: calpha_r <= q_alpha;
        default:   ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.kind <= cmd.out_kind;
      out_r.last <= cmd.out_last;
      case (cmd.out_kind)
        KIND_UPD: begin
          out_r.out_pos_x       <= p_r[0];
          out_r.out_pos_y       <= p_r[1];
          out_r.out_pos_z       <= p_r[2];
          out_r.out_vel_x       <= v_r[0];
          out_r.out_vel_y       <= v_r[1];
          out_r.out_vel_z       <= v_r[2];
          out_r.out_scale       <= sc_r;
          out_r.out_age         <= age1_r;
          out_r.alpha           <= palpha_r;
          out_r.out_spawn_timer <= tm_r;
        end
        KIND_CHILD: begin
          out_r.out_pos_x       <= cp_r[0];
          out_r.out_pos_y       <= cp_r[1];
          out_r.out_pos_z       <= cp_r[2];
          out_r.out_vel_x       <= '0;
          out_r.out_vel_y       <= '0;
          out_r.out_vel_z       <= '0;
          out_r.out_scale       <= sc_r;
          out_r.out_age         <= ca_r;
          out_r.alpha           <= calpha_r;
          out_r.out_spawn_timer <= '0;
        end
        default: begin
          out_r.out_pos_x       <= '0;
          out_r.out_pos_y       <= '0;
          out_r.out_pos_z       <= '0;
          out_r.out_vel_x       <= '0;
          out_r.out_vel_y       <= '0;
          out_r.out_vel_z       <= '0;
          out_r.out_scale       <= '0;
          out_r.out_age         <= '0;
          out_r.alpha           <= '0;
          out_r.out_spawn_timer <= '0;
        end
      endcase
    end
  end

  // Status back to the controller
  always_comb begin
    sts.expired  = life_r <= age0_r;
    sts.trail    = ctl_r[3] && par_r;
    sts.smode_on = (smode == SMODE_UP) || (smode == SMODE_DOWN);
    sts.tm_ge    = tm_r >= intv_r;
    sts.cnt_n    = cnt_r;
    sts.out_free = out_free;
    sts.div_done = div_done;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/put_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module put_ctrl
  import put_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire put_sts_t sts,
  output put_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_EXP   = 4'd2;
  localparam logic [3:0] ST_MVA   = 4'd3;
  localparam logic [3:0] ST_MVB   = 4'd4;
  localparam logic [3:0] ST_MVC   = 4'd5;
  localparam logic [3:0] ST_MVD   = 4'd6;
  localparam logic [3:0] ST_MVE   = 4'd7;
  localparam logic [3:0] ST_NUM   = 4'd8;
  localparam logic [3:0] ST_DIVS  = 4'd9;
  localparam logic [3:0] ST_DIVW  = 4'd10;
  localparam logic [3:0] ST_TM    = 4'd11;
  localparam logic [3:0] ST_EMITP = 4'd12;
  localparam logic [3:0] ST_EMITC = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [2:0] m_r, m_nxt;      // intervals fired
  logic [2:0] rep_r, rep_nxt;  // interval being emitted
  logic [3:0] i_r, i_nxt;      // child index within interval

  logic plast;
  logic clast;
  assign plast = (m_r == 3'd0) || (sts.cnt_n == 4'd0);
  assign clast = (rep_r == m_r) && (i_r == sts.cnt_n);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    m_nxt     = m_r;
    rep_nxt   = rep_r;
    i_nxt     = i_r;
    cmd       = '0;
    cmd.mv      = MV_NONE;
    cmd.num_op  = op_r;
    cmd.child_i = i_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          m_nxt       = '0;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: state_nxt = sts.expired ? ST_EXP : ST_MVA;
      ST_EXP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_EXP;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_MVA: begin cmd.mv = MV_A; state_nxt = ST_MVB; end
      ST_MVB: begin cmd.mv = MV_B; state_nxt = ST_MVC; end
      ST_MVC: begin cmd.mv = MV_C; state_nxt = ST_MVD; end
      ST_MVD: begin cmd.mv = MV_D; state_nxt = ST_MVE; end
      ST_MVE: begin
        cmd.mv = MV_E;
        if (sts.smode_on) begin
          op_nxt    = OP_SCALE;
          state_nxt = ST_NUM;
        end else begin
          state_nxt = ST_TM;
        end
      end
      ST_NUM: begin
        cmd.num_load = 1'b1;
        state_nxt    = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          cmd.store = 1'b1;
          state_nxt = ST_NUM;
          case (op_r)
            OP_SCALE:  state_nxt = ST_TM;
            OP_PALPHA: state_nxt = ST_EMITP;
            OP_CX:     op_nxt = OP_CY;
            OP_CY:     op_nxt = OP_CZ;
            OP_CZ:     op_nxt = OP_CAGE;
            OP_CAGE:   op_nxt = OP_CALPHA;
            default:   state_nxt = ST_EMITC;
          endcase
        end
      end
      // Drain the spawn timer one interval per cycle
      ST_TM: begin
        if (sts.trail && (m_r < 3'(MAX_INTERVALS)) && sts.tm_ge) begin
          cmd.tm_step = 1'b1;
          m_nxt       = m_r + 3'd1;
        end else begin
          op_nxt    = OP_PALPHA;
          state_nxt = ST_NUM;
        end
      end
      ST_EMITP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_UPD;
          cmd.out_last = plast;
          if (plast) begin
            state_nxt = ST_IDLE;
          end else begin
            rep_nxt   = 3'd1;
            i_nxt     = 4'd1;
            op_nxt    = OP_CX;
            state_nxt = ST_NUM;
          end
        end
      end
      ST_EMITC: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_CHILD;
          cmd.out_last = clast;
          if (clast) begin
            state_nxt = ST_IDLE;
          end else begin
            if (i_r == sts.cnt_n) begin
              i_nxt   = 4'd1;
              rep_nxt = rep_r + 3'd1;
            end else begin
              i_nxt = i_r + 4'd1;
            end
            op_nxt    = OP_CX;
            state_nxt = ST_NUM;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_SCALE;
      m_r     <= '0;
      rep_r   <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      m_r     <= m_nxt;
      rep_r   <= rep_nxt;
      i_r     <= i_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/particle_update_trail_spawner_core.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | in_data   (in_item_t)
// out     | output    | out_valid/out_stall | out_data  (out_item_t)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Expired particle: accept, check, emit. Live particle: accept, check,
// 5 motion steps, timer steps (m intervals fired, at most 4), divisions
// in the shared radix-16 divider for the scale (when a scale mode is on),
// the parent alpha and five per child, and one emit per result.
// Synchronous active-low reset; config regs return to their defaults.
// A stalled output holds the sequencer at its emit step.
`timescale 1ns / 1ps
`default_nettype none

module particle_update_trail_spawner_core
  import put_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  put_cmd_t cmd;
  put_sts_t sts;

  assign cfg_ready = 1'b1;

  put_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  put_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // Expired records always close their input
  a_exp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_EXP) |-> out_data.last)
    else $error("expired result without last");

  // Children are motionless and carry no timer
  a_child_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_CHILD) |->
      (out_data.out_vel_x == 16'sd0) && (out_data.out_vel_y == 16'sd0) &&
      (out_data.out_vel_z == 16'sd0) && (out_data.out_spawn_timer == 16'd0))
    else $error("trail child with motion or timer");

  // Alpha never exceeds fully opaque
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alpha <= 9'(ALPHA_ONE)))
    else $error("alpha out of range");

  // No new input is taken in the cycle a result is loaded
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid || $past(out_valid))
    else $error("result appeared right after an accept");
`endif

endmodule

`default_nettype wire
